// ===== design/bfsm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bfsm_pkg
// Shared constants, types and the prime table of the Bloom filter block.
// ---------------------------------------------------------------------------
package bfsm_pkg;

  localparam int unsigned MaxBits   = 65536;
  localparam int unsigned MaxHashes = 16;
  localparam int unsigned IdxW      = $clog2(MaxBits);
  localparam int unsigned SlotW     = (MaxHashes > 1) ? $clog2(MaxHashes) : 1;
  localparam int unsigned CfgW      = 17;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CoefW     = 62;
  localparam int unsigned NumPrimes = 14;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned ClearRows = MaxBits;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdQuery  = 2'd1,
    CmdLoad   = 2'd2,
    CmdClear  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegNumBits    = 2'd0,
    RegNumHashes  = 2'd1,
    RegPrimeIndex = 2'd2,
    RegNone       = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_byte;
    logic             last_byte;
    logic [3:0]       coef_slot;
    logic [CoefW-1:0] coef_mult;
    logic [CoefW-1:0] coef_add;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic present;
  } out_item_t;

  // Work item from the front end to the back end.
  typedef struct packed {
    cmd_e             cmd;
    logic [63:0]      hash;
    logic [3:0]       slot;
    logic [CoefW-1:0] mult;
    logic [CoefW-1:0] add;
  } job_t;

  function automatic logic [63:0] prime_of(input logic [3:0] sel);
    logic [63:0] p;
    unique case (sel)
      4'd0:  p = 64'd2;
      4'd1:  p = 64'd29;
      4'd2:  p = 64'd677;
      4'd3:  p = 64'd17579;
      4'd4:  p = 64'd456979;
      4'd5:  p = 64'd11881379;
      4'd6:  p = 64'd308915797;
      4'd7:  p = 64'd8031810211;
      4'd8:  p = 64'd208827064597;
      4'd9:  p = 64'd5429503679023;
      4'd10: p = 64'd141167095653379;
      4'd11: p = 64'd3670344486987793;
      4'd12: p = 64'd95428956661682197;
      default: p = 64'd2481152873203736609;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/bfsm_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bfsm_in_if / bfsm_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface bfsm_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [7:0]               char_byte;
  logic                     last_byte;
  logic [3:0]               coef_slot;
  logic [bfsm_pkg::CoefW-1:0] coef_mult;
  logic [bfsm_pkg::CoefW-1:0] coef_add;
  modport source (output valid, cmd, char_byte, last_byte, coef_slot, coef_mult,
                  coef_add, input ready);
  modport sink (input valid, cmd, char_byte, last_byte, coef_slot, coef_mult,
                coef_add, output ready);
endinterface

interface bfsm_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic present;
  modport source (output valid, result_kind, present, input ready);
  modport sink (input valid, result_kind, present, output ready);
endinterface
`default_nettype wire

// ===== design/bfsm_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bfsm_front
// Accepts items, folds word bytes into the running hash and queues jobs.
// ---------------------------------------------------------------------------
module bfsm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bfsm_in_if.sink            in_if,
  output bfsm_pkg::job_t     job_o,
  output logic               job_valid_o,
  input  wire logic          job_ready_i
);
  import bfsm_pkg::*;

  logic [63:0] hash_q, hash_d;
  logic [63:0] h1, h2;
  job_t        q_mem [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth):0]   cnt_q;
  logic        acc, push, pop, is_word;
  job_t        job_new;

  assign in_if.ready = (cnt_q != QDepth[$clog2(QDepth):0]);
  assign acc         = in_if.valid && in_if.ready;
  assign is_word     = (in_if.cmd == CmdInsert) || (in_if.cmd == CmdQuery);

  always_comb begin
    h1     = hash_q + {{56{in_if.char_byte[7]}}, in_if.char_byte};
    h1     = h1 + (h1 << 10);
    h2     = h1 ^ (h1 >> 6);
    hash_d = hash_q;
    if (acc && is_word) begin
      hash_d = in_if.last_byte ? 64'd0 : h2;
    end
  end

  assign push = acc && (!is_word || in_if.last_byte);
  assign pop  = job_valid_o && job_ready_i;

  always_comb begin
    job_new.cmd  = cmd_e'(in_if.cmd);
    job_new.hash = h2;
    job_new.slot = in_if.coef_slot;
    job_new.mult = in_if.coef_mult;
    job_new.add  = in_if.coef_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      hash_q <= hash_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= job_new;
  end

  assign job_o       = q_mem[rp_q];
  assign job_valid_o = (cnt_q != '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QDepth) else $error("queue overflow");
  a_hash_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_word && in_if.last_byte) |=> hash_q == 64'd0)
    else $error("hash not cleared at word end");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == QDepth) |-> !push) else $error("push into full queue");

endmodule
`default_nettype wire

// ===== design/bfsm_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bfsm_back
// Executes queued jobs: coefficient loads, clear sweeps and word probes.
// Each probe runs a split 64-bit multiply, a bit-serial modulo by the
// prime and a bit-serial modulo by num_bits, then one filter memory access.
// ---------------------------------------------------------------------------
module bfsm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  bfsm_pkg::job_t     job_i,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire logic [16:0]   num_bits_i,
  input  wire logic [4:0]    num_hashes_i,
  input  wire logic [3:0]    prime_index_i,
  bfsm_out_if.source         out_if
);
  import bfsm_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StClear, StMul, StAdd, StMod1, StMod2, StRead, StWait, StCheck, StOut
  } state_e;

  state_e      st_q;
  logic [CoefW-1:0] mult_mem [MaxHashes];
  logic [CoefW-1:0] add_mem  [MaxHashes];
  logic        fmem [MaxBits];
  logic        rd_q;
  logic [IdxW-1:0] clr_q;
  logic [IdxW:0]   clr_cnt_q;
  logic [SlotW-1:0] k_q;
  logic [SlotW:0]   nk_q;
  logic [1:0]  part_q;
  logic [63:0] acc_q, hash_q, rem_q, prime_q;
  logic [CoefW-1:0] a_q, b_q;
  logic [6:0]  bit_q;
  logic [IdxW:0] mod_q;
  logic [IdxW-1:0] idx_q;
  logic        insert_q, all_q;
  logic [16:0] nb_eff;
  logic [4:0]  nh_eff;
  logic [64:0] r1sh;
  logic [IdxW+1:0] m2sh;
  logic [63:0] pp;

  always_comb begin
    if (num_bits_i == 17'd0) nb_eff = 17'd1;
    else if (num_bits_i > 17'(MaxBits)) nb_eff = 17'(MaxBits);
    else nb_eff = num_bits_i;
    if (num_hashes_i == 5'd0) nh_eff = 5'd1;
    else if (num_hashes_i > 5'(MaxHashes)) nh_eff = 5'(MaxHashes);
    else nh_eff = num_hashes_i;
  end

  // One 16x64 partial product per cycle; low 64 bits kept.
  always_comb begin
    pp = '0;
    for (int j = 0; j < 4; j++) begin
      pp = pp + ((64'(16'({2'b00, a_q} >> {part_q, 4'b0000})) *
                  64'(16'(hash_q >> (16*j)))) << (16*j));
    end
  end

  assign r1sh = {rem_q, acc_q[63]};
  assign m2sh = {mod_q, rem_q[63]};

  assign job_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && job_valid_i && job_ready_o && job_i.cmd == CmdLoad &&
        {1'b0, job_i.slot} < 5'(MaxHashes)) begin
      mult_mem[SlotW'(job_i.slot)] <= job_i.mult;
      add_mem[SlotW'(job_i.slot)]  <= job_i.add;
    end
    if (st_q == StClear) fmem[clr_q] <= 1'b0;
    else if (st_q == StCheck && insert_q) fmem[idx_q] <= 1'b1;
    rd_q <= fmem[idx_q];
    a_q  <= mult_mem[k_q];
    b_q  <= add_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClear;
      clr_q   <= '0;
      clr_cnt_q <= '0;
      out_if.valid <= 1'b0;
      k_q <= '0; nk_q <= '0; part_q <= '0; bit_q <= '0;
      insert_q <= 1'b0; all_q <= 1'b1;
      hash_q <= '0; acc_q <= '0; rem_q <= '0; prime_q <= '0;
      mod_q <= '0; idx_q <= '0;
      out_if.result_kind <= 1'b0; out_if.present <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) out_if.valid <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (job_valid_i && job_ready_o) begin
            unique case (job_i.cmd)
              CmdClear: begin
                clr_q <= '0; clr_cnt_q <= '0; st_q <= StClear;
              end
              CmdLoad: st_q <= StIdle;
              default: begin
                hash_q   <= job_i.hash;
                insert_q <= (job_i.cmd == CmdInsert);
                all_q    <= 1'b1;
                k_q      <= '0;
                nk_q     <= (SlotW+1)'(nh_eff);
                prime_q  <= prime_of(prime_index_i > 4'd13 ? 4'd13 : prime_index_i);
                st_q     <= StMul;
                part_q   <= '0;
                acc_q    <= '0;
              end
            endcase
          end
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == (IdxW+1)'(ClearRows - 1)) st_q <= StIdle;
        end
        StMul: begin
          // a_q is valid in the cycle after k_q is set; part 0 uses a stale read
          // so the first cycle only waits.
          if (part_q == 2'd0 && acc_q == '0 && bit_q == 7'd0) begin
            bit_q <= 7'd1;
          end else begin
            acc_q  <= acc_q + (pp << {part_q, 4'b0000});
            part_q <= part_q + 1'b1;
            if (part_q == 2'd3) st_q <= StAdd;
          end
        end
        StAdd: begin
          acc_q <= acc_q + {2'b00, b_q};
          rem_q <= '0;
          bit_q <= 7'd64;
          st_q  <= StMod1;
        end
        StMod1: begin
          if ({1'b0, prime_q} <= r1sh) rem_q <= 64'(r1sh - {1'b0, prime_q});
          else rem_q <= r1sh[63:0];
          acc_q <= acc_q << 1;
          bit_q <= bit_q - 1'b1;
          if (bit_q == 7'd1) begin
            st_q <= StMod2; bit_q <= 7'd64; mod_q <= '0;
          end
        end
        StMod2: begin
          if ((IdxW+2)'(nb_eff) <= m2sh) mod_q <= (IdxW+1)'(m2sh - (IdxW+2)'(nb_eff));
          else mod_q <= m2sh[IdxW:0];
          rem_q <= rem_q << 1;
          bit_q <= bit_q - 1'b1;
          if (bit_q == 7'd1) st_q <= StRead;
        end
        StRead: begin
          idx_q <= mod_q[IdxW-1:0];
          st_q  <= StWait;
        end
        StWait: st_q <= StCheck;
        StCheck: begin
          if (!insert_q && !rd_q) all_q <= 1'b0;
          if ((SlotW+1)'(k_q) + 1'b1 == nk_q) begin
            st_q <= StOut;
          end else begin
            k_q <= k_q + 1'b1; part_q <= '0; acc_q <= '0; bit_q <= '0;
            st_q <= StMul;
          end
        end
        StOut: begin
          if (!out_if.valid) begin
            out_if.valid <= 1'b1;
            out_if.result_kind <= !insert_q;
            out_if.present <= !insert_q && all_q;
            bit_q <= '0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> st_q == StIdle) else $error("ready outside idle");
  a_ins_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.result_kind) |-> !out_if.present)
    else $error("insert reports present");
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRead) |-> ((IdxW+1)'(nb_eff) > mod_q)) else $error("index out of range");

endmodule
`default_nettype wire

// ===== design/bloom_filter_string_membership.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bloom_filter_string_membership
// Bloom filter over byte strings with a front hash stage and a back probe unit.
// ---------------------------------------------------------------------------
// Each word byte is hashed combinationally in the front end; the front end keeps
// taking bytes while a two-entry job queue has room. For a word's last byte the
// back end runs, per hash, a coefficient read, a 4-step multiply, an add, two
// bit-serial 64-step modulo units and filter memory access and check in
// StRead, StWait and StCheck, after taking the job in StIdle and before
// presenting the result in StOut. A clear command, and reset itself, sweep the
// 65536-bit filter memory one bit a cycle, during which no job is taken from
// the queue.
module bloom_filter_string_membership (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i,
  bfsm_in_if.sink          in_if,
  bfsm_out_if.source       out_if
);
  import bfsm_pkg::*;

  logic [16:0] num_bits_q;
  logic [4:0]  num_hashes_q;
  logic [3:0]  prime_index_q;
  job_t        job;
  logic        job_valid, job_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bits_q    <= 17'd65536;
      num_hashes_q  <= 5'd4;
      prime_index_q <= 4'd13;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        RegNumBits:    num_bits_q    <= cfg_data_i;
        RegNumHashes:  num_hashes_q  <= cfg_data_i[4:0];
        RegPrimeIndex: prime_index_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  bfsm_front u_front (
    .clk_i, .rst_ni, .in_if,
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  bfsm_back u_back (
    .clk_i, .rst_ni,
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready),
    .num_bits_i(num_bits_q), .num_hashes_i(num_hashes_q),
    .prime_index_i(prime_index_q), .out_if
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bloom filter string membership block. A directed
// table and then random words, coefficient loads and clears are sent through
// the input channel under several register settings; every result transfer is
// compared with a table result or the output of an in-bench filter predictor.
// ---------------------------------------------------------------------------
module testbench;
  import bfsm_pkg::*;

  localparam logic [63:0] PrimeTbl [NumPrimes] = '{
    64'd2, 64'd29, 64'd677, 64'd17579, 64'd456979, 64'd11881379, 64'd308915797,
    64'd8031810211, 64'd208827064597, 64'd5429503679023, 64'd141167095653379,
    64'd3670344486987793, 64'd95428956661682197, 64'd2481152873203736609
  };
  localparam logic [CoefW-1:0] CoefMax = {CoefW{1'b1}};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [16:0] cfg_data;

  bfsm_in_if  in_bus ();
  bfsm_out_if out_bus ();

  bloom_filter_string_membership dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // Predictor state.
  logic [16:0]      bits_reg;
  logic [4:0]       hashes_reg;
  logic [3:0]       prime_reg;
  logic [63:0]      word_hash;
  bit               filter_bits [MaxBits];
  logic [CoefW-1:0] mult_coef [MaxHashes];
  logic [CoefW-1:0] add_coef [MaxHashes];

  out_item_t   pending_results [$];
  row_t        rows [$];
  int unsigned error_count;
  int unsigned burst_left;
  bit          clear_since_idle;
  int unsigned clears_left;

  logic [7:0]  saved_words [16][6];
  int unsigned saved_len [16];
  int unsigned saved_count;
  int unsigned saved_next;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic void filter_step(input in_item_t it, output bit has_res,
                                      output out_item_t res);
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] nbits;
    logic [63:0] p;
    int unsigned nh;
    int unsigned idx;
    bit all_set;
    has_res = 1'b0;
    res = '0;
    all_set = 1'b1;
    if (it.cmd == CmdLoad) begin
      mult_coef[it.coef_slot] = it.coef_mult;
      add_coef[it.coef_slot] = it.coef_add;
      return;
    end
    if (it.cmd == CmdClear) begin
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      return;
    end
    h = word_hash + {{56{it.char_byte[7]}}, it.char_byte};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    word_hash = h;
    if (!it.last_byte) return;
    nbits = (bits_reg == 0) ? 64'd1 : (bits_reg > MaxBits) ? 64'(MaxBits) : 64'(bits_reg);
    nh = (hashes_reg == 0) ? 1 : (hashes_reg > MaxHashes) ? MaxHashes : hashes_reg;
    p = PrimeTbl[(prime_reg > 13) ? 13 : prime_reg];
    for (int unsigned s = 0; s < nh; s++) begin
      m = 64'(mult_coef[s]);
      a = 64'(add_coef[s]);
      v = m * h + a;
      idx = int'((v % p) % nbits);
      if (it.cmd == CmdInsert) filter_bits[idx] = 1'b1;
      else if (!filter_bits[idx]) all_set = 1'b0;
    end
    word_hash = '0;
    has_res = 1'b1;
    res.result_kind = it.cmd[0];
    res.present = (it.cmd == CmdQuery) && all_set;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    bit has_res;
    out_item_t res;
    if (burst_left == 0) begin
      int unsigned gap;
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= it.cmd;
    in_bus.char_byte <= it.char_byte;
    in_bus.last_byte <= it.last_byte;
    in_bus.coef_slot <= it.coef_slot;
    in_bus.coef_mult <= it.coef_mult;
    in_bus.coef_add  <= it.coef_add;
    do @(posedge clk_i); while (!in_bus.ready);
    burst_left--;
    if (it.cmd == CmdClear) clear_since_idle = 1'b1;
    filter_step(it, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (clear_since_idle ? 70000 : 3000) @(posedge clk_i);
    clear_since_idle = 1'b0;
  endtask

  task automatic write_reg(input reg_e idx, input logic [16:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      RegNumBits:    bits_reg = data;
      RegNumHashes:  hashes_reg = data[4:0];
      RegPrimeIndex: prime_reg = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [16:0] nb, input logic [16:0] nh, input logic [16:0] pi);
    write_reg(RegNumBits, nb);
    write_reg(RegNumHashes, nh);
    write_reg(RegPrimeIndex, pi);
    write_reg(RegNone, 17'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t rand_item(input logic [1:0] cmd);
    in_item_t it;
    it.cmd       = cmd;
    it.char_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.coef_slot = 4'($urandom);
    it.coef_mult = {30'($urandom), 32'($urandom)};
    it.coef_add  = {30'($urandom), 32'($urandom)};
    if (it.coef_mult == 0) it.coef_mult = 1;
    return it;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [7:0] b, input bit last,
                         input bit typed, input bit kind, input bit pres);
    row_t r;
    r.item = '0;
    r.item.cmd = cmd;
    r.item.char_byte = b;
    r.item.last_byte = last;
    r.item.coef_slot = 4'd15;
    r.item.coef_mult = CoefMax;
    r.item.coef_add = CoefMax;
    r.typed = typed;
    r.result.result_kind = kind;
    r.result.present = pres;
    rows.push_back(r);
  endtask

  task automatic send_word(input int unsigned reuse);
    in_item_t it;
    int unsigned len;
    int unsigned slot;
    bit store;
    slot = reuse ? $urandom_range(0, saved_count - 1) : saved_next;
    len = reuse ? saved_len[slot] : $urandom_range(1, 6);
    store = 1'b0;
    for (int unsigned k = 0; k < len; k++) begin
      it = rand_item({1'b0, 1'($urandom)});
      it.last_byte = (k == len - 1);
      if (reuse) begin
        it.char_byte = saved_words[slot][k];
        if (it.last_byte) it.cmd = CmdQuery;
      end else begin
        saved_words[slot][k] = it.char_byte;
        if (it.last_byte && it.cmd == CmdInsert) store = 1'b1;
      end
      send_item(it, 1'b0, '0);
    end
    if (store) begin
      saved_len[slot] = len;
      saved_next = (saved_next + 1) % 16;
      if (saved_count < 16) saved_count++;
    end
  endtask

  task automatic random_phase(input int unsigned items, input bit hold_mid);
    int unsigned sent;
    int unsigned r;
    in_item_t it;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (hold_mid && sent >= items / 2) begin
        hold_mid = 1'b0;
        in_bus.valid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      if (r < 4) begin
        send_item(rand_item(CmdLoad), 1'b0, '0);
        sent++;
      end else if (r == 4 && clears_left != 0) begin
        clears_left--;
        send_item(rand_item(CmdClear), 1'b0, '0);
        sent++;
      end else if (r < 40 && saved_count != 0) begin
        send_word(1);
        sent += 3;
      end else begin
        send_word(0);
        sent += 3;
      end
    end
  endtask

  always @(posedge clk_i) begin
    int unsigned mode;
    out_item_t want;
    if (out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result transfer: kind %0d present %0d",
                   out_bus.result_kind, out_bus.present);
      end else begin
        want = pending_results.pop_front();
        if (want.result_kind !== out_bus.result_kind || want.present !== out_bus.present) begin
          error_count++;
          if (error_count <= 10)
            $display("result mismatch: expected kind %0d present %0d, got kind %0d present %0d",
                     want.result_kind, want.present, out_bus.result_kind, out_bus.present);
        end
      end
    end
    mode = 32'(($time / 1000) % 3);
    case (mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= 1'($urandom);
      default: out_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    in_item_t it;
    error_count = 0;
    burst_left = 0;
    clear_since_idle = 1'b0;
    clears_left = 1;
    saved_count = 0;
    saved_next = 0;
    bits_reg = 17'd65536;
    hashes_reg = 5'd4;
    prime_reg = 4'd13;
    word_hash = '0;
    foreach (filter_bits[i]) filter_bits[i] = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegNone;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CmdInsert;
    in_bus.char_byte = '0;
    in_bus.last_byte = 1'b0;
    in_bus.coef_slot = '0;
    in_bus.coef_mult = '0;
    in_bus.coef_add = '0;
    out_bus.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every coefficient slot is loaded before any word ends.
    for (int unsigned s = 0; s < MaxHashes; s++) begin
      it = rand_item(CmdLoad);
      it.coef_slot = 4'(s);
      if (s == 0) begin
        it.coef_mult = 1;
        it.coef_add = 0;
      end else if (s == 1) begin
        it.coef_mult = CoefMax;
        it.coef_add = CoefMax;
      end
      send_item(it, 1'b0, '0);
    end

    add_row(CmdQuery,  8'h61, 1, 1, 1, 0);
    add_row(CmdInsert, 8'h00, 1, 1, 0, 0);
    add_row(CmdInsert, 8'hFF, 0, 0, 0, 0);
    add_row(CmdInsert, 8'h80, 1, 1, 0, 0);
    add_row(CmdQuery,  8'h00, 1, 0, 0, 0);
    add_row(CmdQuery,  8'hFF, 0, 0, 0, 0);
    add_row(CmdQuery,  8'h80, 1, 0, 0, 0);
    add_row(CmdInsert, 8'h7F, 0, 0, 0, 0);
    add_row(CmdQuery,  8'h01, 1, 0, 0, 0);
    add_row(CmdQuery,  8'h41, 0, 0, 0, 0);
    add_row(CmdLoad,   8'h00, 0, 0, 0, 0);
    add_row(CmdQuery,  8'h42, 1, 0, 0, 0);
    add_row(CmdInsert, 8'h41, 0, 0, 0, 0);
    add_row(CmdQuery,  8'h42, 1, 0, 0, 0);
    add_row(CmdClear,  8'h00, 0, 0, 0, 0);
    add_row(CmdQuery,  8'h00, 1, 1, 1, 0);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);

    wait_idle();
    set_regs(17'd1, 17'd1, 17'd0);
    random_phase(90, 1'b0);
    wait_idle();
    set_regs(17'd65536, 17'd16, 17'd13);
    random_phase(60, 1'b1);
    wait_idle();
    set_regs(17'd0, 17'd0, 17'h1FFFF);
    random_phase(90, 1'b0);
    wait_idle();
    set_regs(17'h1FFFF, 17'h1FFFF, 17'd14);
    random_phase(60, 1'b0);
    wait_idle();
    set_regs(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 16)),
             17'($urandom_range(0, 13)));
    random_phase(110, 1'b0);
    wait_idle();
    set_regs(17'($urandom_range(1, 300)), 17'($urandom_range(1, 4)),
             17'($urandom_range(0, 13)));
    random_phase(110, 1'b0);

    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
